// ===== rtl/mme_pkg.sv =====
package mme_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed field widths of the stream and configuration ports.
    localparam int COUNT_W   = 4;
    localparam int IDX_W     = 3;
    localparam int IN_VAL_W  = 16;
    localparam int OUT_VAL_W = 32;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 40;

    // Configuration register indexes.
    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    // Input item kinds carried on the slave tuser.
    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_START  = 2'd2
    } action_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ERROR
    } state_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic issue;
        logic first;
    } mac_ctrl_t;

    // A count of zero acts as one, a count above the limit acts as the limit.
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count,
                                                     input logic [COUNT_W-1:0] limit);
        logic [COUNT_W-1:0] res;
        res = count;
        if (count == '0)
            res = 4'd1;
        else if (count > limit)
            res = limit;
        return res;
    endfunction

endpackage

// ===== rtl/matrix_multiply_engine_top.sv =====
// Load items are taken in ST_IDLE, and the block stays idle and ready after each one.
// A start item with matching shapes computes each result element in turn through the
// one shared MAC: inner read/multiply steps in ST_RUN, then ST_DRAIN waits for the RAM
// read, multiply and accumulate registers and a free output register before it is emitted.
// A start item with mismatched shapes goes to ST_ERROR, which emits its error item.
// Reset sets all four counts to 8 and clears the accumulator; stores are undefined.
module matrix_multiply_engine_top #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [mme_pkg::COUNT_W-1:0]   cfg_data,
    // Input items.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: elem_row [2:0], elem_col [5:3], elem_value [21:6], zero fill [23:22]
    input  logic [mme_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: action [1:0]
    input  logic [1:0]                    s_axis_tuser,
    // Result items.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: product_value [31:0], out_row [34:32], out_col [37:35], zero fill [39:38]
    output logic [mme_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,
    // tuser: shape_error [0]
    output logic                          m_axis_tuser
);

    import mme_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DIM_LIMIT = COUNT_W'(MAX_DIM);
    localparam logic [7:0]         DIM_MUL   = 8'(MAX_DIM);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [COUNT_W-1:0] ar, ac, br, bc;

    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;
    logic                m_err_reg, m_err_next;
    logic                out_free;

    action_t           action;
    logic [IDX_W-1:0]  in_row, in_col;
    logic [IN_VAL_W-1:0] in_value;
    logic              load_ok;
    logic              elem_last;
    logic              k_last;

    logic                  a_wr_en, b_wr_en;
    logic [ADDR_W-1:0]     wr_addr, a_rd_addr, b_rd_addr;
    logic [ELEM_WIDTH-1:0] wr_data, a_rd_data, b_rd_data;
    logic [7:0]            wr_addr_full, a_addr_full, b_addr_full;

    mac_ctrl_t                    mac_ctrl;
    logic                         mac_busy;
    logic signed [OUT_VAL_W-1:0]  mac_result;

    // Field unpacking.
    assign action   = action_t'(s_axis_tuser);
    assign in_row   = s_axis_tdata[2:0];
    assign in_col   = s_axis_tdata[5:3];
    assign in_value = s_axis_tdata[21:6];

    // Effective sizes.
    assign ar = eff_count(a_rows_reg, DIM_LIMIT);
    assign ac = eff_count(a_cols_reg, DIM_LIMIT);
    assign br = eff_count(b_rows_reg, DIM_LIMIT);
    assign bc = eff_count(b_cols_reg, DIM_LIMIT);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= COUNT_RESET;
            a_cols_reg <= COUNT_RESET;
            b_rows_reg <= COUNT_RESET;
            b_cols_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_A_ROWS: a_rows_reg <= cfg_data;
                REG_A_COLS: a_cols_reg <= cfg_data;
                REG_B_ROWS: b_rows_reg <= cfg_data;
                REG_B_COLS: b_cols_reg <= cfg_data;
                default:    a_rows_reg <= a_rows_reg;
            endcase
        end
    end

    // Element width conversion for stored values.
    generate
        if (ELEM_WIDTH >= IN_VAL_W)
        begin : g_wide
            assign wr_data = ELEM_WIDTH'($signed(in_value));
        end
        else
        begin : g_narrow
            assign wr_data = in_value[ELEM_WIDTH-1:0];
        end
    endgenerate

    // Load bounds check against the addressed matrix.
    always_comb
    begin
        if (action == ACT_LOAD_A)
            load_ok = ({1'b0, in_row} < ar) && ({1'b0, in_col} < ac);
        else
            load_ok = ({1'b0, in_row} < br) && ({1'b0, in_col} < bc);
    end

    // Store addresses are row * MAX_DIM + column.
    assign wr_addr_full = 8'(in_row) * DIM_MUL + 8'(in_col);
    assign a_addr_full  = 8'(i_reg) * DIM_MUL + 8'(k_reg);
    assign b_addr_full  = 8'(k_reg) * DIM_MUL + 8'(j_reg);
    assign wr_addr      = wr_addr_full[ADDR_W-1:0];
    assign a_rd_addr    = a_addr_full[ADDR_W-1:0];
    assign b_rd_addr    = b_addr_full[ADDR_W-1:0];

    assign k_last    = ({1'b0, k_reg} + 4'd1) == ac;
    assign elem_last = (({1'b0, i_reg} + 4'd1) == ar) && (({1'b0, j_reg} + 4'd1) == bc);
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && action == ACT_START)
                begin
                    if (ac != br)
                        state_next = ST_ERROR;
                    else
                        state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!mac_busy && out_free)
                    state_next = elem_last ? ST_IDLE : ST_RUN;
            end
            ST_ERROR:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath next values.
    always_comb
    begin
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        a_wr_en      = 1'b0;
        b_wr_en      = 1'b0;
        mac_ctrl     = '0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (action)
                        ACT_LOAD_A: a_wr_en = load_ok;
                        ACT_LOAD_B: b_wr_en = load_ok;
                        ACT_START:
                        begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                        end
                        default: k_next = k_reg;
                    endcase
                end
            end
            ST_RUN:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.first = (k_reg == '0);
                k_next         = k_reg + 3'd1;
            end
            ST_DRAIN:
            begin
                if (!mac_busy && out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, j_reg, i_reg, mac_result};
                    m_last_next  = elem_last;
                    m_err_next   = 1'b0;
                    k_next       = '0;
                    if (({1'b0, j_reg} + 4'd1) == bc)
                    begin
                        j_next = '0;
                        i_next = i_reg + 3'd1;
                    end
                    else
                    begin
                        j_next = j_reg + 3'd1;
                    end
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_last_next  = 1'b1;
                    m_err_next   = 1'b1;
                end
            end
            default: m_valid_next = m_valid_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_err_reg;

    // Element stores for A and B.
    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // Shared multiply-accumulate unit.
    mme_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_rd_data),
        .b_data (b_rd_data),
        .busy   (mac_busy),
        .result (mac_result)
    );

endmodule

// ===== rtl/mme_ram.sv =====
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/mme_mac.sv =====
module mme_mac #(
    parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mme_pkg::mac_ctrl_t                ctrl,
    input  logic signed [ELEM_WIDTH-1:0]      a_data,
    input  logic signed [ELEM_WIDTH-1:0]      b_data,
    output logic                              busy,
    output logic signed [mme_pkg::OUT_VAL_W-1:0] result
);

    import mme_pkg::*;

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int ACC_W  = (PROD_W + 8 > OUT_VAL_W + 1) ? PROD_W + 8 : OUT_VAL_W + 1;

    logic                     issue_d1_reg;
    logic                     first_d1_reg;
    logic                     prod_v_reg;
    logic                     first_d2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [ACC_W-OUT_VAL_W:0] upper;

    // Stage valid bits: read data arrives in the cycle after the issue, with issue_d1_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_d1_reg <= 1'b0;
            first_d1_reg <= 1'b0;
            prod_v_reg   <= 1'b0;
            first_d2_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            issue_d1_reg <= ctrl.issue;
            first_d1_reg <= ctrl.first;
            prod_v_reg   <= issue_d1_reg;
            first_d2_reg <= first_d1_reg;
            acc_reg      <= acc_next;
        end
    end

    // The single multiplier, registered before the add.
    always_ff @(posedge clk)
    begin
        if (issue_d1_reg)
        begin
            prod_reg <= a_data * b_data;
        end
    end

    // Accumulate; the first product of an element restarts the sum.
    always_comb
    begin
        acc_next = acc_reg;
        if (prod_v_reg)
        begin
            if (first_d2_reg)
                acc_next = ACC_W'(prod_reg);
            else
                acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = issue_d1_reg | prod_v_reg;

    // Saturate the sum to the signed output range.
    assign upper = acc_reg[ACC_W-1:OUT_VAL_W-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
            result = acc_reg[OUT_VAL_W-1:0];
        else if (acc_reg[ACC_W-1])
            result = {1'b1, {(OUT_VAL_W-1){1'b0}}};
        else
            result = {1'b0, {(OUT_VAL_W-1){1'b1}}};
    end

endmodule
